/* rtl/cfs_pkg.sv */
`default_nettype none

package cfs_pkg;

  // Fixed field widths of the channels and the configuration register.
  localparam int DATA_W  = 16;
  localparam int TAP_W   = 4;
  localparam int LEN_W   = 5;
  localparam int SHIFT_W = 3;

  // The longest kernel the length register can select.
  localparam int MAX_LEN = 16;

  // Exact product of a signed sample and an unsigned weight, and the running sum of up to
  // sixteen of them.
  localparam int PROD_W = 33;
  localparam int ACC_W  = 38;

  // Rounding constant and shift of the Q.15 sum.
  localparam int RND_HALF  = 16384;
  localparam int FRAC_BITS = 15;

  // Operation codes of an input item.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic             hist_wr;   // push the incoming sample into the history
    logic             wt_wr;     // write the incoming coefficient
    logic             tap_use;   // this cycle's tap contributes to the sum
    logic [TAP_W-1:0] tap_ofs;   // age of the history entry for this tap
    logic [TAP_W-1:0] tap_idx;   // weight index for this tap
    logic             acc_clr;   // start a new sum
    logic             out_load;  // round the sum into the output register
    logic             out_end;   // buffer_end flag of that result
  } cfs_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic out_free;  // the output register can take a new result this cycle
  } cfs_sts_t;

endpackage

`default_nettype wire

/* rtl/cfs_in_if.sv */
`default_nettype none

interface cfs_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic        [cfs_pkg::TAP_W-1:0]  tap_index;
  logic        [cfs_pkg::DATA_W-1:0] coefficient;
  logic signed [cfs_pkg::DATA_W-1:0] sample;
  logic                              last_sample;

  modport source (
    output valid, operation, tap_index, coefficient, sample, last_sample,
    input  ready
  );

  modport sink (
    input  valid, operation, tap_index, coefficient, sample, last_sample,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/cfs_out_if.sv */
`default_nettype none

interface cfs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cfs_pkg::DATA_W-1:0] smoothed;
  logic                              buffer_end;

  modport source (
    output valid, smoothed, buffer_end,
    input  ready
  );

  modport sink (
    input  valid, smoothed, buffer_end,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/cfs_datapath.sv */
`default_nettype none

module cfs_datapath #(
  parameter int MAX_TAPS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire cfs_pkg::cfs_cmd_t                 cmd_i,
  output cfs_pkg::cfs_sts_t                      sts_o,
  input  wire logic        [cfs_pkg::TAP_W-1:0]  in_tap_index_i,
  input  wire logic        [cfs_pkg::DATA_W-1:0] in_coefficient_i,
  input  wire logic signed [cfs_pkg::DATA_W-1:0] in_sample_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic signed [cfs_pkg::DATA_W-1:0]      out_smoothed_o,
  output logic                                   out_buffer_end_o
);

  localparam int AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int PAW = AW + 6;
  localparam int DW  = cfs_pkg::DATA_W;
  localparam int ACW = cfs_pkg::ACC_W;

  localparam logic signed [ACW-1:0] SAT_HI = ACW'(32767);
  localparam logic signed [ACW-1:0] SAT_LO = ACW'(-32768);

  // Kernel weights and the circular sample history.
  logic [DW-1:0] wt_mem [MAX_TAPS];
  logic [DW-1:0] hist_mem [MAX_TAPS];

  logic [AW-1:0]  ptr_q, ptr_d;
  logic [AW-1:0]  hist_raddr;
  logic [AW-1:0]  wt_waddr;
  logic [AW-1:0]  wt_raddr;
  logic           wt_we;
  logic signed [PAW-1:0] raddr_s;

  logic        [DW-1:0]                wt_rd_q;
  logic signed [DW-1:0]                hist_rd_q;
  logic                                use1_q, use2_q;
  logic signed [cfs_pkg::PROD_W-1:0]   prod_q, prod_d;
  logic signed [ACW-1:0]               acc_q, acc_d;
  logic signed [ACW-1:0]               rnd, quo;
  logic signed [DW-1:0]                sat;

  logic                                out_valid_q, out_valid_d;
  logic signed [DW-1:0]                out_data_q;
  logic                                out_end_q;

  // Newest sample sits one slot behind the write pointer; wrap once.
  always_comb begin
    raddr_s = $signed({6'b0, ptr_q}) - $signed(PAW'(1)) - $signed(PAW'(cmd_i.tap_ofs));
    if (raddr_s < 0) begin
      raddr_s = raddr_s + $signed(PAW'(MAX_TAPS));
    end
    hist_raddr = raddr_s[AW-1:0];
  end

  always_comb begin
    if (ptr_q == AW'(MAX_TAPS - 1)) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_q + AW'(1);
    end
  end

  assign wt_waddr = AW'(in_tap_index_i);
  assign wt_raddr = AW'(cmd_i.tap_idx);
  assign wt_we    = cmd_i.wt_wr && (int'(in_tap_index_i) < MAX_TAPS);

  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= in_coefficient_i;
    end
    wt_rd_q <= wt_mem[wt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_wr) begin
      hist_mem[ptr_q] <= in_sample_i;
    end
    hist_rd_q <= hist_mem[hist_raddr];
  end

  // Multiply into the product register, then accumulate from it.
  assign prod_d = hist_rd_q * $signed({1'b0, wt_rd_q});

  always_comb begin
    if (cmd_i.acc_clr) begin
      acc_d = '0;
    end else if (use2_q) begin
      acc_d = acc_q + ACW'(prod_q);
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  // Round half up, floor by the shift, then clamp to 16 bits.
  always_comb begin
    rnd = acc_q + ACW'(cfs_pkg::RND_HALF);
    quo = rnd >>> cfs_pkg::FRAC_BITS;
    priority if (quo > SAT_HI) begin
      sat = SAT_HI[DW-1:0];
    end else if (quo < SAT_LO) begin
      sat = SAT_LO[DW-1:0];
    end else begin
      sat = quo[DW-1:0];
    end
  end

  always_comb begin
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= sat;
      out_end_q  <= cmd_i.out_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      use1_q      <= 1'b0;
      use2_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.hist_wr) begin
        ptr_q <= ptr_d;
      end
      use1_q      <= cmd_i.tap_use;
      use2_q      <= use1_q;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_smoothed_o   = out_data_q;
  assign out_buffer_end_o = out_end_q;

endmodule

`default_nettype wire

/* rtl/cfs_ctrl.sv */
`default_nettype none

module cfs_ctrl #(
  parameter int MAX_TAPS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [cfs_pkg::LEN_W-1:0]  cfg_wdata_i,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_operation_i,
  input  wire logic                       in_last_i,
  output logic                            in_ready_o,
  input  wire cfs_pkg::cfs_sts_t          sts_i,
  output cfs_pkg::cfs_cmd_t               cmd_o
);

  localparam int LIM = (MAX_TAPS < cfs_pkg::MAX_LEN) ? MAX_TAPS : cfs_pkg::MAX_LEN;
  localparam int SW  = $clog2(MAX_TAPS + 1);
  localparam int LW  = cfs_pkg::LEN_W;
  localparam int TW  = cfs_pkg::TAP_W;
  localparam int HW  = cfs_pkg::SHIFT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TAPS  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e         state_q, state_d;
  logic [LW-1:0]  len_cfg_q;
  logic [SW-1:0]  seen_q, seen_d, seen_inc;
  logic [TW-1:0]  j_q, j_d;
  logic [HW-1:0]  shift_q, shift_d;
  logic           last_q, last_d;
  logic           drain_q, drain_d;

  logic [LW-1:0]  len_eff;
  logic [LW-1:0]  ahead5;
  logic [HW-1:0]  ahead;
  logic [LW-1:0]  k5;
  logic [TW-1:0]  k, ofs, sh4;
  logic           tap_last;
  logic           accept;

  always_comb begin
    priority if (len_cfg_q == '0) begin
      len_eff = LW'(1);
    end else if (int'(len_cfg_q) > LIM) begin
      len_eff = LW'(LIM);
    end else begin
      len_eff = len_cfg_q;
    end
  end

  // Number of outputs that lag the newest sample.
  assign ahead5 = len_eff - LW'(1) - (len_eff >> 1);
  assign ahead  = ahead5[HW-1:0];

  assign seen_inc = (seen_q == SW'(MAX_TAPS)) ? seen_q : seen_q + SW'(1);

  // Tap j multiplies the sample k positions older than the newest one needed.
  assign k5       = len_eff - LW'(1) - LW'(j_q);
  assign k        = k5[TW-1:0];
  assign sh4      = TW'(shift_q);
  assign ofs      = k - sh4;
  assign tap_last = (LW'(j_q) == len_eff - LW'(1));

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    seen_d  = seen_q;
    j_d     = j_q;
    shift_d = shift_q;
    last_d  = last_q;
    drain_d = drain_q;
    cmd_o   = '0;
    cmd_o.tap_idx = j_q;
    cmd_o.tap_ofs = ofs;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_operation_i == cfs_pkg::OP_LOAD) begin
            cmd_o.wt_wr = 1'b1;
          end else begin
            cmd_o.hist_wr = 1'b1;
            seen_d = seen_inc;
            j_d    = '0;
            last_d = in_last_i;
            if (in_last_i) begin
              if (int'(seen_inc) > int'(ahead)) begin
                shift_d = '0;
              end else begin
                shift_d = HW'(int'(ahead) + 1 - int'(seen_inc));
              end
              state_d = S_TAPS;
            end else if (int'(seen_inc) > int'(ahead)) begin
              shift_d = '0;
              state_d = S_TAPS;
            end
          end
        end
      end

      S_TAPS: begin
        cmd_o.acc_clr = (j_q == '0);
        cmd_o.tap_use = (k >= sh4) && (int'(ofs) < int'(seen_q));
        if (tap_last) begin
          drain_d = 1'b0;
          state_d = S_DRAIN;
        end else begin
          j_d = j_q + TW'(1);
        end
      end

      S_DRAIN: begin
        // Wait here while the read and the multiply of the last tap reach the sum.
        if (drain_q) begin
          state_d = S_EMIT;
        end else begin
          drain_d = 1'b1;
        end
      end

      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_end  = last_q && (shift_q == ahead);
          if (last_q && (shift_q != ahead)) begin
            shift_d = shift_q + HW'(1);
            j_d     = '0;
            state_d = S_TAPS;
          end else begin
            if (last_q) begin
              seen_d = '0;
            end
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_cfg_q <= LW'(1);
      seen_q    <= '0;
      j_q       <= '0;
      shift_q   <= '0;
      last_q    <= 1'b0;
      drain_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      j_q     <= j_d;
      shift_q <= shift_d;
      last_q  <= last_d;
      drain_q <= drain_d;
      if (cfg_we_i) begin
        len_cfg_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/centered_fir_smoother.sv */
`default_nettype none

// Channel   Direction  Transfer carries
// in_i      sink       operation, tap_index, coefficient, sample, last_sample
// out_o     source     smoothed, buffer_end
// cfg       write      kernel_length (cfg_we_i, cfg_wdata_i)
//
// When a sample releases an output, one shared multiply-accumulate walks the L taps, where L is
// the kernel length in use, then the memory read and the product drain; no input is taken
// meanwhile. The last sample of a buffer releases up to L - 1 - L/2 + 1 outputs in turn.
// Reset is asynchronous and active low; it clears the control state, the length register
// (to 1) and the sample count, and needs no clearing pass.
// A stalled output is held in its register; the next input transfer is still taken, and the
// sequencer waits only when a new result is ready before the previous one has left.

module centered_fir_smoother #(
  parameter int MAX_TAPS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [cfs_pkg::LEN_W-1:0]  cfg_wdata_i,
  cfs_in_if.sink                          in_i,
  cfs_out_if.source                       out_o
);

  cfs_pkg::cfs_cmd_t cmd;
  cfs_pkg::cfs_sts_t sts;

  // The sequencer owns the length register, the per-buffer sample count and the tap walk.
  cfs_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_i.valid),
    .in_operation_i (in_i.operation),
    .in_last_i      (in_i.last_sample),
    .in_ready_o     (in_i.ready),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // The datapath holds the weight and history memories, the multiplier, the sum and the
  // output register. Samples older than the current buffer are masked by the count, so
  // the history never has to be cleared.
  cfs_datapath #(
    .MAX_TAPS (MAX_TAPS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_tap_index_i   (in_i.tap_index),
    .in_coefficient_i (in_i.coefficient),
    .in_sample_i      (in_i.sample),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_smoothed_o   (out_o.smoothed),
    .out_buffer_end_o (out_o.buffer_end)
  );

endmodule

`default_nettype wire
